### rtl/legendre_derivative_evaluator_defines.svh
// Assertion macros for the Legendre derivative evaluator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LEGENDRE_DERIVATIVE_EVALUATOR_DEFINES_SVH
`define LEGENDRE_DERIVATIVE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define LDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define LDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lde_pkg.sv
// Shared types and constants for the Legendre derivative evaluator.
// No dependencies; used by lde_ctrl, lde_dpath and the top level.
package lde_pkg;

  localparam int MAX_DEGREE = 16;
  localparam int MAX_DERIV  = 2;
  localparam int FRAC_BITS  = 24;

  localparam int POINT_W = 26;
  localparam int DEG_W   = 5;
  localparam int ORD_W   = 2;
  localparam int VAL_W   = 48;

  // Recurrence step coefficients: 2i-1, i-1+k, i-k
  localparam int C1_W = DEG_W + 1;
  localparam int C2_W = DEG_W;
  localparam int DV_W = DEG_W;

  // Radix-256 long division of the step numerator magnitude
  localparam int DIGIT_W    = 8;
  localparam int DIV_DIGITS = 8;
  localparam int NUM_W      = DIGIT_W * DIV_DIGITS;
  localparam int DCNT_W     = $clog2(DIV_DIGITS);

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // (2k-1)!! for k = 0 .. 8
  localparam int DF_LEN   = 9;
  localparam int DF_W     = 22;
  localparam int DF_IDX_W = $clog2(DF_LEN);
  localparam logic [DF_W-1:0] DFACT [DF_LEN] = '{
    22'd1, 22'd1, 22'd3, 22'd15, 22'd105, 22'd945, 22'd10395, 22'd135135, 22'd2027025
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MLO,
    OP_MHI,
    OP_TSUM,
    OP_D1,
    OP_D2,
    OP_DABS,
    OP_DIV,
    OP_WB,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ORD_W-1:0] load_k;
    logic             load_zero;
    logic [C1_W-1:0]  c1;
    logic [C2_W-1:0]  c2;
    logic [DV_W-1:0]  dv;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

### rtl/lde_ctrl.sv
// Sequencer for the Legendre derivative evaluator: walks the recurrence
// steps and issues datapath commands. Depends on lde_pkg.
module lde_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [lde_pkg::DEG_W-1:0] degree,
  input  logic [lde_pkg::ORD_W-1:0] deriv_order,
  input  lde_pkg::stat_t            stat,
  output lde_pkg::cmd_t             cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MLO,
    S_MHI,
    S_TSUM,
    S_D1,
    S_D2,
    S_DABS,
    S_DIV,
    S_WB,
    S_DONE
  } state_t;

  state_t                       state_r;
  logic [lde_pkg::DEG_W-1:0]    i_r;
  logic [lde_pkg::DEG_W-1:0]    n_r;
  logic [lde_pkg::ORD_W-1:0]    k_r;
  logic [lde_pkg::DCNT_W-1:0]   dcnt_r;

  logic                         accept;
  logic [lde_pkg::DEG_W-1:0]    n_clip;
  logic [lde_pkg::ORD_W-1:0]    k_clip;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign n_clip = (degree > lde_pkg::DEG_W'(lde_pkg::MAX_DEGREE)) ?
                  lde_pkg::DEG_W'(lde_pkg::MAX_DEGREE) : degree;
  assign k_clip = (deriv_order > lde_pkg::ORD_W'(lde_pkg::MAX_DERIV)) ?
                  lde_pkg::ORD_W'(lde_pkg::MAX_DERIV) : deriv_order;

  always_comb begin
    cmd           = '0;
    cmd.op        = lde_pkg::OP_NONE;
    cmd.load_k    = k_clip;
    cmd.load_zero = ({{(lde_pkg::DEG_W-lde_pkg::ORD_W){1'b0}}, k_clip} > n_clip);
    cmd.c1        = lde_pkg::C1_W'({i_r, 1'b0} - 1'b1);
    cmd.c2        = lde_pkg::C2_W'(i_r - 1'b1
                    + {{(lde_pkg::DEG_W-lde_pkg::ORD_W){1'b0}}, k_r});
    cmd.dv        = lde_pkg::DV_W'(i_r
                    - {{(lde_pkg::DEG_W-lde_pkg::ORD_W){1'b0}}, k_r});
    unique case (state_r)
      S_IDLE: begin
        if (accept) cmd.op = lde_pkg::OP_LOAD;
      end
      S_MLO:  cmd.op = lde_pkg::OP_MLO;
      S_MHI:  cmd.op = lde_pkg::OP_MHI;
      S_TSUM: cmd.op = lde_pkg::OP_TSUM;
      S_D1:   cmd.op = lde_pkg::OP_D1;
      S_D2:   cmd.op = lde_pkg::OP_D2;
      S_DABS: cmd.op = lde_pkg::OP_DABS;
      S_DIV:  cmd.op = lde_pkg::OP_DIV;
      S_WB:   cmd.op = lde_pkg::OP_WB;
      S_DONE: begin
        if (!stat.out_busy) cmd.op = lde_pkg::OP_EMIT;
      end
      default: cmd.op = lde_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dcnt_r  <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            n_r <= n_clip;
            k_r <= k_clip;
            i_r <= lde_pkg::DEG_W'({{(lde_pkg::DEG_W-lde_pkg::ORD_W){1'b0}}, k_clip}
                   + 1'b1);
            // no recurrence steps when k >= n
            if ({{(lde_pkg::DEG_W-lde_pkg::ORD_W){1'b0}}, k_clip} >= n_clip) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_MLO;
            end
          end
        end
        S_MLO:  state_r <= S_MHI;
        S_MHI:  state_r <= S_TSUM;
        S_TSUM: state_r <= S_D1;
        S_D1:   state_r <= S_D2;
        S_D2:   state_r <= S_DABS;
        S_DABS: begin
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == lde_pkg::DCNT_W'(lde_pkg::DIV_DIGITS - 1)) state_r <= S_WB;
        end
        S_WB: begin
          if (i_r == n_r) begin
            state_r <= S_DONE;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_MLO;
          end
        end
        S_DONE: begin
          if (!stat.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/lde_dpath.sv
// Datapath of the Legendre derivative evaluator: split multiply, step sum,
// radix-256 divider, saturation and the result register. Depends on lde_pkg.
module lde_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lde_pkg::cmd_t                    cmd,
  output lde_pkg::stat_t                   stat,
  input  logic signed [lde_pkg::POINT_W-1:0] point,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic signed [lde_pkg::VAL_W-1:0] out_value,
  output logic                             out_overflow
);

  localparam int LP_W = lde_pkg::POINT_W + lde_pkg::FRAC_BITS + 1;
  localparam int HP_W = lde_pkg::POINT_W + lde_pkg::VAL_W - lde_pkg::FRAC_BITS;
  localparam int T_W  = HP_W + 1;
  localparam int D_W  = T_W + lde_pkg::C1_W + 1;
  localparam int Q_W  = lde_pkg::NUM_W + 1;
  localparam int R_W  = lde_pkg::DV_W;

  logic signed [lde_pkg::POINT_W-1:0] x_r;
  logic signed [lde_pkg::VAL_W-1:0]   p1_r;
  logic signed [lde_pkg::VAL_W-1:0]   p2_r;
  logic signed [LP_W-1:0]             lp_r;
  logic signed [HP_W-1:0]             hp_r;
  logic signed [T_W-1:0]              t_r;
  logic signed [D_W-1:0]              d_r;
  logic [lde_pkg::NUM_W-1:0]          num_r;
  logic [R_W-1:0]                     rem_r;
  logic                               neg_r;
  logic                               ovf_r;

  logic                               out_valid_r;
  logic signed [lde_pkg::VAL_W-1:0]   out_value_r;
  logic                               out_ovf_r;

  logic [lde_pkg::DIGIT_W-1:0]        qdig;
  logic [R_W-1:0]                     rem_nxt;
  logic [D_W-1:0]                     dmag;
  logic signed [Q_W-1:0]              q_full;
  logic                               q_hi;
  logic                               q_lo;

  // One quotient digit: eight restoring steps on a remainder below the divisor
  always_comb begin
    logic [R_W-1:0] r;
    r = rem_r;
    for (int j = 0; j < lde_pkg::DIGIT_W; j++) begin
      r = {r[R_W-2:0], num_r[lde_pkg::NUM_W-1-j]};
      if (r >= cmd.dv) begin
        r                          = r - cmd.dv;
        qdig[lde_pkg::DIGIT_W-1-j] = 1'b1;
      end else begin
        qdig[lde_pkg::DIGIT_W-1-j] = 1'b0;
      end
    end
    rem_nxt = r;
  end

  assign dmag   = d_r[D_W-1] ? D_W'(-d_r) : D_W'(d_r);
  assign q_full = neg_r ? -$signed({1'b0, num_r}) : $signed({1'b0, num_r});
  assign q_hi   = (q_full > Q_W'(lde_pkg::VAL_MAX));
  assign q_lo   = (q_full < Q_W'(lde_pkg::VAL_MIN));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      lde_pkg::OP_LOAD: begin
        x_r   <= point;
        p2_r  <= '0;
        ovf_r <= 1'b0;
        if (cmd.load_zero) begin
          p1_r <= '0;
        end else begin
          p1_r <= $signed({{(lde_pkg::VAL_W-lde_pkg::DF_W-lde_pkg::FRAC_BITS){1'b0}},
                           lde_pkg::DFACT[lde_pkg::DF_IDX_W'(cmd.load_k)],
                           {lde_pkg::FRAC_BITS{1'b0}}});
        end
      end
      lde_pkg::OP_MLO: begin
        lp_r <= x_r * $signed({1'b0, p1_r[lde_pkg::FRAC_BITS-1:0]});
      end
      lde_pkg::OP_MHI: begin
        hp_r <= x_r * $signed(p1_r[lde_pkg::VAL_W-1:lde_pkg::FRAC_BITS]);
      end
      lde_pkg::OP_TSUM: begin
        // floor(x*v / 2^24) = hi part + floor(lo part / 2^24)
        t_r <= T_W'(hp_r) + T_W'(lp_r >>> lde_pkg::FRAC_BITS);
      end
      lde_pkg::OP_D1: begin
        d_r <= $signed({1'b0, cmd.c1}) * t_r;
      end
      lde_pkg::OP_D2: begin
        d_r <= d_r - $signed({1'b0, cmd.c2}) * p2_r;
      end
      lde_pkg::OP_DABS: begin
        neg_r <= d_r[D_W-1];
        num_r <= lde_pkg::NUM_W'(dmag);
        rem_r <= '0;
      end
      lde_pkg::OP_DIV: begin
        num_r <= {num_r[lde_pkg::NUM_W-lde_pkg::DIGIT_W-1:0], qdig};
        rem_r <= rem_nxt;
      end
      lde_pkg::OP_WB: begin
        p2_r <= p1_r;
        if (q_hi) begin
          p1_r  <= lde_pkg::VAL_MAX;
          ovf_r <= 1'b1;
        end else if (q_lo) begin
          p1_r  <= lde_pkg::VAL_MIN;
          ovf_r <= 1'b1;
        end else begin
          p1_r <= q_full[lde_pkg::VAL_W-1:0];
        end
      end
      lde_pkg::OP_EMIT: begin
        out_value_r <= p1_r;
        out_ovf_r   <= ovf_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == lde_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid_r && !out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_value     = out_value_r;
  assign out_overflow  = out_ovf_r;

endmodule

### rtl/legendre_derivative_evaluator.sv
// Top level of the Legendre derivative evaluator: sequencer plus datapath.
// Depends on lde_pkg, lde_ctrl, lde_dpath and the assertion macro header.
//
// Usage notes
//  - in_* channel: one transfer carries point x (Q1.24, signed), degree n and
//    derivative order k. n is clipped to 16, k to 2.
//  - out_* channel: one transfer per input, the k-th derivative of P_n at x in
//    signed Q23.24 on out_tdata and the saturation flag on out_tuser.
//  - k > n returns zero; k = n returns (2k-1)!! with no recurrence step.
//  - Each recurrence step runs on the shared datapath: 26x25 and 26x24
//    partial products, the step sum, two coefficient products, the
//    magnitude, eight radix-256 quotient digits and a saturating write-back.
//  - An item runs n-k recurrence steps, then its result is loaded into the
//    output register. One item at a time: in_tready rises at the edge that
//    loads the output reg.
//  - The next input is taken while a finished result waits in the output
//    register; a stalled receiver only holds the block once the following
//    result is ready.
//  - Reset (rst_n low, synchronous) empties the output register and returns
//    the sequencer to idle; no clearing pass.
`include "legendre_derivative_evaluator_defines.svh"

module legendre_derivative_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [25:0] point, [30:26] degree, [32:31] deriv_order
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] value
  output logic [0:0]  out_tuser   // [0] overflow
);

  lde_pkg::cmd_t  cmd;
  lde_pkg::stat_t stat;

  logic signed [lde_pkg::POINT_W-1:0] point;
  logic [lde_pkg::DEG_W-1:0]          degree;
  logic [lde_pkg::ORD_W-1:0]          deriv_order;
  logic signed [lde_pkg::VAL_W-1:0]   value;
  logic                               overflow;

  // unpack input fields, lowest field first
  assign point       = $signed(in_tdata[lde_pkg::POINT_W-1:0]);
  assign degree      = in_tdata[lde_pkg::POINT_W +: lde_pkg::DEG_W];
  assign deriv_order = in_tdata[lde_pkg::POINT_W + lde_pkg::DEG_W +: lde_pkg::ORD_W];

  lde_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .degree      (degree),
    .deriv_order (deriv_order),
    .stat        (stat),
    .cmd         (cmd)
  );

  lde_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .point        (point),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_value    (value),
    .out_overflow (overflow)
  );

  assign out_tdata    = value;
  assign out_tuser[0] = overflow;

  // after an input transfer the block is busy with that item
  `LDE_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")

  // a fresh result only appears while an item was in flight
  `LDE_ASSERT_NOW(a_result_from_item, $rose(out_tvalid), $past(!in_tready), "result from idle")

  // the output register is never overwritten while a result is stalled
  `LDE_ASSERT_NOW(a_no_overwrite, cmd.op == lde_pkg::OP_EMIT,
                  !(out_tvalid && !out_tready), "result overwritten")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for legendre_derivative_evaluator: table-driven directed items, then
// random items under four handshake-pressure phases. Needs lde_pkg and the RTL.
module testbench;

  localparam int RANDOM_PER_PHASE = 250;
  localparam int STALL_LIMIT      = 3000;  // cycles with no transfer on either channel
  localparam int TAIL_CYCLES      = 300;

  // Expected result of one transfer.
  typedef struct packed {
    logic signed [lde_pkg::VAL_W-1:0] value;
    logic                             ovf;
  } deriv_result_t;

  // One directed item; pinned rows carry their own expected result.
  typedef struct packed {
    logic signed [lde_pkg::POINT_W-1:0] point;
    logic [lde_pkg::DEG_W-1:0]          degree;
    logic [lde_pkg::ORD_W-1:0]          order;
    bit                                 pinned;
    logic signed [lde_pkg::VAL_W-1:0]   value;
    bit                                 ovf;
  } stim_row_t;

  localparam int DIR_ROWS = 22;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [0:0]  out_tuser;

  // Sideband that travels with in_tdata: a pinned expectation for directed rows.
  bit                               row_pinned = 1'b0;
  logic signed [lde_pkg::VAL_W-1:0] row_value = '0;
  bit                               row_ovf = 1'b0;

  deriv_result_t expected_q[$];
  stim_row_t     dir_rows [DIR_ROWS];
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            fail_count = 0;
  int            quiet_cycles = 0;

  legendre_derivative_evaluator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // k-th derivative of P_n at x. Degree and order are clipped, the start value is
  // (2k-1)!!, and each step runs in 128-bit signed math so the x*v product is exact.
  function automatic deriv_result_t legendre_deriv(logic signed [lde_pkg::POINT_W-1:0] x,
                                                   logic [lde_pkg::DEG_W-1:0] deg,
                                                   logic [lde_pkg::ORD_W-1:0] ord);
    int                   n;
    int                   k;
    logic signed [127:0]  xw;
    logic signed [127:0]  v1;
    logic signed [127:0]  v2;
    logic signed [127:0]  t;
    logic signed [127:0]  d;
    logic signed [127:0]  q;
    longint               dfact;
    deriv_result_t        r;
    n = (deg > lde_pkg::MAX_DEGREE) ? lde_pkg::MAX_DEGREE : int'(deg);
    k = (ord > lde_pkg::MAX_DERIV) ? lde_pkg::MAX_DERIV : int'(ord);
    r.value = '0;
    r.ovf = 1'b0;
    if (k > n) return r;
    dfact = 1;
    for (int j = 1; j <= k; j++) dfact = dfact * (2 * j - 1);
    xw = x;
    v1 = 128'(dfact) <<< lde_pkg::FRAC_BITS;
    v2 = '0;
    for (int i = k + 1; i <= n; i++) begin
      t = (xw * v1) >>> lde_pkg::FRAC_BITS;  // floor of the Q24 product
      d = (2 * i - 1) * t - (i - 1 + k) * v2;
      q = d / (i - k);                       // truncates toward zero
      if (q > lde_pkg::VAL_MAX) begin
        q = lde_pkg::VAL_MAX;
        r.ovf = 1'b1;
      end else if (q < lde_pkg::VAL_MIN) begin
        q = lde_pkg::VAL_MIN;
        r.ovf = 1'b1;
      end
      v2 = v1;
      v1 = q;
    end
    r.value = v1[lde_pkg::VAL_W-1:0];
    return r;
  endfunction

  // Present one item, with a random gap ahead of it, and hold it until the transfer.
  task automatic send_item(input logic signed [lde_pkg::POINT_W-1:0] x,
                           input logic [lde_pkg::DEG_W-1:0] deg,
                           input logic [lde_pkg::ORD_W-1:0] ord, input bit pin,
                           input logic signed [lde_pkg::VAL_W-1:0] pval, input bit povf);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tdata   <= {7'd0, ord, deg, x};
    row_pinned <= pin;
    row_value  <= pval;
    row_ovf    <= povf;
    do @(posedge clk); while (!in_tready);
  endtask

  // Sender holds off until every result is back.
  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Receiver backpressure.
  always @(posedge clk) begin
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Scoreboard: predict on every input transfer, compare on every output transfer.
  always @(posedge clk) begin
    deriv_result_t want;
    bit            moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        if (row_pinned) begin
          want.value = row_value;
          want.ovf   = row_ovf;
        end else begin
          want = legendre_deriv(in_tdata[25:0], in_tdata[30:26], in_tdata[32:31]);
        end
        expected_q = {expected_q, want};
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: value %0d", $signed(out_tdata));
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if ($signed(out_tdata) !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, $signed(out_tdata));
            fail_count++;
          end
          if (out_tuser[0] !== want.ovf) begin
            $error("overflow: expected %0d, got %0d", want.ovf, out_tuser[0]);
            fail_count++;
          end
        end
      end
      // Watchdog: a hung handshake on either side ends the run.
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic signed [lde_pkg::POINT_W-1:0] x;
    logic [lde_pkg::DEG_W-1:0]          deg;
    logic [lde_pkg::ORD_W-1:0]          ord;
    int                                 tmp;

    // point, degree, order, pinned, value, overflow
    dir_rows = '{
      // order 0 at degree 0: constant one
      '{26'sd0,          5'd0,  2'd0, 1'b1, 48'sd16777216,  1'b0},
      // order above degree gives zero
      '{26'sd12345,      5'd0,  2'd1, 1'b1, 48'sd0,         1'b0},
      '{-26'sd33554432,  5'd1,  2'd2, 1'b1, 48'sd0,         1'b0},
      '{26'sd33554431,   5'd0,  2'd3, 1'b1, 48'sd0,         1'b0},  // order clipped to 2
      // order equal to degree: (2k-1)!!
      '{26'sd33554431,   5'd1,  2'd1, 1'b1, 48'sd16777216,  1'b0},
      '{-26'sd33554432,  5'd2,  2'd2, 1'b1, 48'sd50331648,  1'b0},
      '{26'sd7,          5'd2,  2'd3, 1'b1, 48'sd50331648,  1'b0},  // clipped order hits n
      // P_1(x) = x at both point extremes
      '{26'sd33554431,   5'd1,  2'd0, 1'b1, 48'sd33554431,  1'b0},
      '{-26'sd33554432,  5'd1,  2'd0, 1'b1, -48'sd33554432, 1'b0},
      // the rest comes from the predictor
      '{26'sd0,          5'd31, 2'd3, 1'b0, 48'sd0, 1'b0},  // both clipped
      '{26'sd33554431,   5'd16, 2'd0, 1'b0, 48'sd0, 1'b0},  // saturates
      '{-26'sd33554432,  5'd16, 2'd0, 1'b0, 48'sd0, 1'b0},
      '{26'sd33554431,   5'd16, 2'd2, 1'b0, 48'sd0, 1'b0},
      '{-26'sd33554432,  5'd31, 2'd2, 1'b0, 48'sd0, 1'b0},
      '{26'sd0,          5'd16, 2'd1, 1'b0, 48'sd0, 1'b0},
      '{26'sd16777216,   5'd16, 2'd0, 1'b0, 48'sd0, 1'b0},  // x = 1.0
      '{-26'sd16777216,  5'd16, 2'd0, 1'b0, 48'sd0, 1'b0},  // x = -1.0
      '{26'sd8388608,    5'd17, 2'd0, 1'b0, 48'sd0, 1'b0},  // degree clipped
      '{-26'sd1,         5'd5,  2'd1, 1'b0, 48'sd0, 1'b0},
      '{26'sd22369621,   5'd10, 2'd2, 1'b0, 48'sd0, 1'b0},
      '{26'sd1,          5'd3,  2'd0, 1'b0, 48'sd0, 1'b0},
      '{26'sd33554431,   5'd31, 2'd0, 1'b0, 48'sd0, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r])
      send_item(dir_rows[r].point, dir_rows[r].degree, dir_rows[r].order,
                dir_rows[r].pinned, dir_rows[r].value, dir_rows[r].ovf);
    drain();

    // Phases: free-running, sender gaps, receiver stalls, light mix of both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: begin  // the usual domain, |x| <= 1
            tmp = int'($urandom_range(1 << 25)) - (1 << 24);
            x = tmp[lde_pkg::POINT_W-1:0];
          end
          5, 6, 7: x = lde_pkg::POINT_W'($urandom);
          8: begin
            case ($urandom_range(4))
              0:       x = 26'sd33554431;
              1:       x = -26'sd33554432;
              2:       x = 26'sd16777216;
              3:       x = -26'sd16777216;
              default: x = 26'sd0;
            endcase
          end
          default: begin
            tmp = int'($urandom_range(512)) - 256;
            x = tmp[lde_pkg::POINT_W-1:0];
          end
        endcase
        deg = ($urandom_range(9) == 0) ? lde_pkg::DEG_W'($urandom_range(31, 17))
                                       : lde_pkg::DEG_W'($urandom_range(16));
        ord = lde_pkg::ORD_W'($urandom_range(3));
        send_item(x, deg, ord, 1'b0, '0, 1'b0);
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lde_pkg.sv
rtl/lde_ctrl.sv
rtl/lde_dpath.sv
rtl/legendre_derivative_evaluator.sv
tb/testbench.sv
